/* rtl/u2c_pkg.sv */
// Package for the UTF-8 to Windows-1252 transcoder: result type, lead byte
// constants, the reverse table for 0x80-0x9F and the code point mapper.
// No dependencies.
package u2c_pkg;

    // One result word as it travels through the output queue
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       text_done;
    } result_t;

    localparam int CP_W        = 21;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Byte class boundaries
    localparam logic [7:0] LEAD4_MIN  = 8'hf0;
    localparam logic [7:0] LEAD3_MIN  = 8'he0;
    localparam logic [7:0] LEAD2_MIN  = 8'hc0;
    localparam logic [7:0] CONT_MIN   = 8'h80;
    localparam logic [7:0] LEAD4_MASK = 8'h07;
    localparam logic [7:0] LEAD3_MASK = 8'h0f;
    localparam logic [7:0] LEAD2_MASK = 8'h1f;
    localparam logic [7:0] CONT_MASK  = 8'h3f;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] TAG_MASK   = 8'hc0;
    localparam logic [7:0] SUBST_CHAR = 8'h3f;
    localparam logic [7:0] HIGH_BASE  = 8'h80;
    localparam logic [7:0] PASS_MIN   = 8'ha0;
    localparam logic [7:0] PASS_MAX   = 8'hff;

    // Code points that land on bytes 0x80-0x9F, in byte order
    localparam logic [15:0] HI_MAP [32] = '{
        16'h20ac, 16'h0081, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
        16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008d, 16'h017d, 16'h008f,
        16'h0090, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
        16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 16'h009d, 16'h017e, 16'h0178
    };

    // Map a code point to its cp1252 byte, '?' when there is none
    function automatic logic [7:0] map_cp(input logic [CP_W-1:0] cp);
        logic [7:0] res;
        res = SUBST_CHAR;
        if (cp < CP_W'(CONT_MIN) || (cp >= CP_W'(PASS_MIN) && cp <= CP_W'(PASS_MAX)))
        begin
            res = cp[7:0];
        end
        else
        begin
            for (int k = 0; k < 32; k++)
            begin
                if (cp == CP_W'(HI_MAP[k]))
                begin
                    res = HIGH_BASE + 8'(k);
                end
            end
        end
        return res;
    endfunction

endpackage

/* rtl/u2c_in_if.sv */
// Request channel carrying one UTF-8 byte or an end-of-text mark.
// No dependencies.
interface u2c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

/* rtl/u2c_out_if.sv */
// Request channel carrying one Windows-1252 result with its flags.
// No dependencies.
interface u2c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       text_done;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output text_done, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input run_last,
                    input text_done, output ready);
endinterface

/* rtl/utf8_to_cp1252_transcoder_core.sv */
// UTF-8 to Windows-1252 transcoder, top level.
// Depends on u2c_pkg, u2c_in_if and u2c_out_if.
//
// Usage:
//   utf8   : one request per UTF-8 byte, or one with end_of_text set to flush
//            a partial sequence and close the text.
//   cp1252 : results; an input request yields zero, one or two of them and
//            run_last marks the last one. The closing result has text_done.
//   Timing : with an empty queue, the first result of a request is valid on
//            cp1252 in the cycle after the request is accepted; otherwise it
//            waits behind the results already queued, one per output cycle.
//   Throughput: one request per cycle while results drain and the queue has room;
//            a cut-short sequence gives two results, each sent on cp1252 by itself.
//            The rate is set by the four-entry result queue, which takes a
//            request whenever at least two entries are free.
//   Reset : clears the sequence state and empties the queue; no request is
//            lost afterwards and utf8.ready is high from the first cycle.
//   Stall : when cp1252.ready is low the head result holds; utf8.ready drops
//            only once fewer than two queue entries are free.
module utf8_to_cp1252_transcoder_core (
    input  logic      clk,
    input  logic      rst_n,
    u2c_in_if.sink    utf8,
    u2c_out_if.source cp1252
);

    logic [u2c_pkg::CP_W-1:0]  partial_reg, partial_next;
    logic [1:0]                remain_reg, remain_next;
    logic [u2c_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [u2c_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [u2c_pkg::CNT_W-1:0] count_reg, count_next;
    u2c_pkg::result_t          queue_reg [u2c_pkg::QUEUE_DEPTH];

    u2c_pkg::result_t          res0, res1, lead_res;
    logic [1:0]                n_res;
    logic                      lead_has;
    logic                      in_acc, out_acc;
    logic                      is_cont, active;
    logic [u2c_pkg::CP_W-1:0]  shifted;
    logic [u2c_pkg::PTR_W-1:0] wr_ptr_1;
    logic [7:0]                b;

    assign b       = utf8.in_byte;
    assign in_acc  = utf8.valid && utf8.ready;
    assign out_acc = cp1252.valid && cp1252.ready;
    assign is_cont = (b & u2c_pkg::TAG_MASK) == u2c_pkg::CONT_TAG;
    assign active  = remain_reg != 2'd0;
    assign shifted = {partial_reg[u2c_pkg::CP_W-7:0], b[5:0]};

    // Take a request while two queue entries are free
    assign utf8.ready = count_reg <= u2c_pkg::CNT_W'(u2c_pkg::QUEUE_DEPTH - 2);

    // Fresh handling of a byte as if no sequence were active
    always_comb
    begin
        lead_res     = '0;
        lead_has     = 1'b0;
        partial_next = '0;
        remain_next  = 2'd0;
        if (b >= u2c_pkg::LEAD4_MIN)
        begin
            partial_next = u2c_pkg::CP_W'(b & u2c_pkg::LEAD4_MASK);
            remain_next  = 2'd3;
        end
        else if (b >= u2c_pkg::LEAD3_MIN)
        begin
            partial_next = u2c_pkg::CP_W'(b & u2c_pkg::LEAD3_MASK);
            remain_next  = 2'd2;
        end
        else if (b >= u2c_pkg::LEAD2_MIN)
        begin
            partial_next = u2c_pkg::CP_W'(b & u2c_pkg::LEAD2_MASK);
            remain_next  = 2'd1;
        end
        else
        begin
            lead_has          = 1'b1;
            lead_res.has_byte = 1'b1;
            lead_res.out_byte = (b >= u2c_pkg::CONT_MIN) ? u2c_pkg::SUBST_CHAR : b;
        end
    end

    // Decode step: results and next sequence state
    logic [u2c_pkg::CP_W-1:0] part_d;
    logic [1:0]               rem_d;
    always_comb
    begin
        res0   = '0;
        res1   = '0;
        n_res  = 2'd0;
        part_d = partial_next;
        rem_d  = remain_next;
        if (utf8.end_of_text)
        begin
            res0.out_byte  = active ? u2c_pkg::map_cp(partial_reg) : 8'h00;
            res0.has_byte  = active;
            res0.run_last  = 1'b1;
            res0.text_done = 1'b1;
            n_res          = 2'd1;
            part_d         = '0;
            rem_d          = 2'd0;
        end
        else if (active && is_cont)
        begin
            rem_d = remain_reg - 2'd1;
            if (remain_reg == 2'd1)
            begin
                res0.out_byte = u2c_pkg::map_cp(shifted);
                res0.has_byte = 1'b1;
                res0.run_last = 1'b1;
                n_res         = 2'd1;
                part_d        = '0;
            end
            else
            begin
                part_d = shifted;
            end
        end
        else if (active)
        begin
            // Cut-short sequence: flush the partial value, then decode the new byte afresh
            res0.out_byte = u2c_pkg::map_cp(partial_reg);
            res0.has_byte = 1'b1;
            if (lead_has)
            begin
                res1          = lead_res;
                res1.run_last = 1'b1;
                n_res         = 2'd2;
            end
            else
            begin
                res0.run_last = 1'b1;
                n_res         = 2'd1;
            end
        end
        else if (lead_has)
        begin
            res0          = lead_res;
            res0.run_last = 1'b1;
            n_res         = 2'd1;
        end
    end

    // Queue pointer and count update
    assign wr_ptr_1 = wr_ptr_reg + u2c_pkg::PTR_W'(1);
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_acc)
        begin
            wr_ptr_next = wr_ptr_reg + u2c_pkg::PTR_W'(n_res);
            count_next  = count_next + u2c_pkg::CNT_W'(n_res);
        end
        if (out_acc)
        begin
            rd_ptr_next = rd_ptr_reg + u2c_pkg::PTR_W'(1);
            count_next  = count_next - u2c_pkg::CNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            remain_reg  <= 2'd0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                partial_reg <= part_d;
                remain_reg  <= rem_d;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result queue entries
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < u2c_pkg::QUEUE_DEPTH; i++)
        begin
            if (in_acc && n_res != 2'd0 && u2c_pkg::PTR_W'(i) == wr_ptr_reg)
            begin
                queue_reg[i] <= res0;
            end
            if (in_acc && n_res == 2'd2 && u2c_pkg::PTR_W'(i) == wr_ptr_1)
            begin
                queue_reg[i] <= res1;
            end
        end
    end

    // Head of queue drives the result channel
    assign cp1252.valid     = count_reg != '0;
    assign cp1252.out_byte  = queue_reg[rd_ptr_reg].out_byte;
    assign cp1252.has_byte  = queue_reg[rd_ptr_reg].has_byte;
    assign cp1252.run_last  = queue_reg[rd_ptr_reg].run_last;
    assign cp1252.text_done = queue_reg[rd_ptr_reg].text_done;

endmodule

/* rtl/u2c_checker.sv */
// Port-level checks for the transcoder and the bind that attaches them.
// Depends on utf8_to_cp1252_transcoder_core.
module u2c_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_eot,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_byte,
    input logic       res_has,
    input logic       res_last,
    input logic       res_done
);

    // A closing result is always the last one of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done |-> res_last)
        else $error("text_done without run_last");

    // An empty result only closes the text, and carries a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_has |-> res_done && res_byte == 8'h00)
        else $error("empty result outside end of text");

    // End of text always queues a result, so one is shown next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_eot |=> res_valid)
        else $error("no result after end of text");

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_has)
            && $stable(res_last) && $stable(res_done))
        else $error("stalled result changed");

endmodule

bind utf8_to_cp1252_transcoder_core u2c_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (utf8.valid),
    .in_ready  (utf8.ready),
    .in_eot    (utf8.end_of_text),
    .res_valid (cp1252.valid),
    .res_ready (cp1252.ready),
    .res_byte  (cp1252.out_byte),
    .res_has   (cp1252.has_byte),
    .res_last  (cp1252.run_last),
    .res_done  (cp1252.text_done)
);

/* tb/tb_utf8_to_cp1252_transcoder_core.sv */
// Self-checking testbench for utf8_to_cp1252_transcoder_core: a queue-fed driver,
// a clocked monitor and a cycle-free decoder that predicts every cp1252 result.
// Depends on u2c_pkg, u2c_in_if, u2c_out_if and the transcoder RTL.
`timescale 1ns / 1ps

module tb_utf8_to_cp1252_transcoder_core;

    // One UTF-8 request as queued for the driver
    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } utf8_req_t;

    localparam int         DIRECTED_MAX = 25;
    localparam int         RANDOM_ITEMS = 1000;
    localparam int         QUIET_TAIL   = 150;
    localparam int         HOLD_AT      = 400;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         STUCK_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 16;
    localparam logic [7:0] QMARK        = u2c_pkg::SUBST_CHAR;

    // Code points that cp1252 places on bytes 0x80-0x9F, in byte order
    localparam logic [20:0] HIGH_CP [32] = '{
        21'h20ac, 21'h0081, 21'h201a, 21'h0192, 21'h201e, 21'h2026, 21'h2020, 21'h2021,
        21'h02c6, 21'h2030, 21'h0160, 21'h2039, 21'h0152, 21'h008d, 21'h017d, 21'h008f,
        21'h0090, 21'h2018, 21'h2019, 21'h201c, 21'h201d, 21'h2022, 21'h2013, 21'h2014,
        21'h02dc, 21'h2122, 21'h0161, 21'h203a, 21'h0153, 21'h009d, 21'h017e, 21'h0178
    };

    logic clk = 1'b0;
    logic rst_n;

    u2c_in_if  utf8_bus ();
    u2c_out_if cp1252_bus ();

    utf8_to_cp1252_transcoder_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .utf8   (utf8_bus),
        .cp1252 (cp1252_bus)
    );

    always #1 clk = ~clk;

    utf8_req_t          utf8_backlog [$];
    u2c_pkg::result_t   cp1252_due [$];
    logic [7:0]         high_byte_of [int];
    int                 utf8_total;
    int                 utf8_taken;
    int                 cp1252_seen;
    int                 mismatches;

    // Decoder state of the prediction
    logic [20:0] seq_code;
    logic [1:0]  seq_left;

    // Idle control
    int          send_gap;
    int          send_idle_pct;
    int          recv_gap;
    int          recv_idle_pct;
    logic        send_offer;
    logic        long_hold;
    logic        hold_done;
    int          hold_left;
    int          stuck_cycles;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 8;
            default: return 25;
        endcase
    endfunction

    // Code point to cp1252 byte, '?' where the charset has none
    function automatic logic [7:0] to_cp1252(input logic [20:0] cp);
        if (cp < 21'h80 || (cp >= 21'ha0 && cp <= 21'hff))
            return cp[7:0];
        if (high_byte_of.exists(int'(cp)))
            return high_byte_of[int'(cp)];
        return QMARK;
    endfunction

    function automatic u2c_pkg::result_t make_result(input logic [7:0] ch, input logic has,
                                                     input logic closes);
        u2c_pkg::result_t r;
        r.out_byte  = ch;
        r.has_byte  = has;
        r.run_last  = 1'b0;
        r.text_done = closes;
        return r;
    endfunction

    // Advance the decoder by one request and queue the cp1252 results it yields
    function automatic void predict_transcode(input utf8_req_t rq);
        u2c_pkg::result_t outs [2];
        int               n;
        logic             handled;
        n       = 0;
        handled = 1'b0;
        if (rq.eot)
        begin
            // flush a partial sequence, or close with an empty result
            outs[0]  = make_result((seq_left != 0) ? to_cp1252(seq_code) : 8'h00,
                                   seq_left != 0, 1'b1);
            n        = 1;
            seq_code = '0;
            seq_left = '0;
            handled  = 1'b1;
        end
        else if (seq_left != 0)
        begin
            if ((rq.data & u2c_pkg::TAG_MASK) == u2c_pkg::CONT_TAG)
            begin
                seq_code = {seq_code[14:0], rq.data[5:0]};
                seq_left = seq_left - 2'd1;
                if (seq_left == 0)
                begin
                    outs[0]  = make_result(to_cp1252(seq_code), 1'b1, 1'b0);
                    n        = 1;
                    seq_code = '0;
                end
                handled = 1'b1;
            end
            else
            begin
                // cut short: emit what was gathered, then decode this byte afresh
                outs[0]  = make_result(to_cp1252(seq_code), 1'b1, 1'b0);
                n        = 1;
                seq_code = '0;
                seq_left = '0;
            end
        end
        if (!handled)
        begin
            if (rq.data >= u2c_pkg::LEAD4_MIN)
            begin
                seq_code = 21'(rq.data & u2c_pkg::LEAD4_MASK);
                seq_left = 2'd3;
            end
            else if (rq.data >= u2c_pkg::LEAD3_MIN)
            begin
                seq_code = 21'(rq.data & u2c_pkg::LEAD3_MASK);
                seq_left = 2'd2;
            end
            else if (rq.data >= u2c_pkg::LEAD2_MIN)
            begin
                seq_code = 21'(rq.data & u2c_pkg::LEAD2_MASK);
                seq_left = 2'd1;
            end
            else if (rq.data >= u2c_pkg::CONT_MIN)
            begin
                outs[n] = make_result(QMARK, 1'b1, 1'b0);
                n++;
            end
            else
            begin
                outs[n] = make_result(rq.data, 1'b1, 1'b0);
                n++;
            end
        end
        for (int k = 0; k < n; k++)
        begin
            outs[k].run_last = (k == n - 1);
            cp1252_due.push_back(outs[k]);
        end
    endfunction

    function automatic void queue_byte(input logic [7:0] b);
        utf8_backlog.push_back('{data: b, eot: 1'b0});
    endfunction

    function automatic void queue_eot(input logic [7:0] junk);
        utf8_backlog.push_back('{data: junk, eot: 1'b1});
    endfunction

    // UTF-8 encode cp in len bytes; cut drops the final continuation byte
    function automatic void queue_code_point(input logic [20:0] cp, input int len,
                                             input bit cut);
        logic [7:0] lead;
        int         n_cont;
        n_cont = len - 1;
        case (len)
            1:       lead = {1'b0, cp[6:0]};
            2:       lead = {3'b110, cp[10:6]};
            3:       lead = {4'b1110, cp[15:12]};
            default: lead = {5'b11110, cp[20:18]};
        endcase
        queue_byte(lead);
        for (int k = n_cont - 1; k >= (cut ? 1 : 0); k--)
            queue_byte({2'b10, cp[6*k +: 6]});
    endfunction

    // Request driver: holds a request until taken, then offers the next or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf8_bus.valid       <= 1'b0;
            utf8_bus.in_byte     <= 8'h00;
            utf8_bus.end_of_text <= 1'b0;
            utf8_taken           <= 0;
            send_gap      = 0;
            send_idle_pct = pick_idle_pct();
            seq_code      = '0;
            seq_left      = '0;
        end
        else
        begin
            send_offer = !utf8_bus.valid;
            if (utf8_bus.valid && utf8_bus.ready)
            begin
                predict_transcode(utf8_backlog.pop_front());
                utf8_taken <= utf8_taken + 1;
                if ((utf8_taken + 1) % 64 == 0)
                    send_idle_pct = pick_idle_pct();
                send_offer = 1'b1;
            end
            if (send_offer)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    utf8_bus.valid <= 1'b0;
                end
                else if (utf8_backlog.size() == 0)
                begin
                    utf8_bus.valid <= 1'b0;
                end
                else if (utf8_taken < utf8_total - QUIET_TAIL &&
                         $urandom_range(99) < send_idle_pct)
                begin
                    send_gap       = $urandom_range(8);
                    utf8_bus.valid <= 1'b0;
                end
                else
                begin
                    utf8_bus.valid       <= 1'b1;
                    utf8_bus.in_byte     <= utf8_backlog[0].data;
                    utf8_bus.end_of_text <= utf8_backlog[0].eot;
                end
            end
        end
    end

    // Result monitor: checks each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        u2c_pkg::result_t want;
        if (!rst_n)
        begin
            cp1252_bus.ready <= 1'b0;
            recv_gap      = 0;
            recv_idle_pct = pick_idle_pct();
            cp1252_seen   = 0;
        end
        else
        begin
            if (cp1252_bus.valid && cp1252_bus.ready)
            begin
                cp1252_seen++;
                if (cp1252_seen % 50 == 0)
                    recv_idle_pct = pick_idle_pct();
                if (cp1252_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result byte %02h has %b last %b done %b",
                        cp1252_bus.out_byte, cp1252_bus.has_byte, cp1252_bus.run_last,
                        cp1252_bus.text_done));
                end
                else
                begin
                    want = cp1252_due.pop_front();
                    if (cp1252_bus.out_byte !== want.out_byte)
                        report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                            cp1252_seen, cp1252_bus.out_byte, want.out_byte));
                    if (cp1252_bus.has_byte !== want.has_byte)
                        report_mismatch($sformatf("result %0d has_byte %b, want %b",
                            cp1252_seen, cp1252_bus.has_byte, want.has_byte));
                    if (cp1252_bus.run_last !== want.run_last)
                        report_mismatch($sformatf("result %0d run_last %b, want %b",
                            cp1252_seen, cp1252_bus.run_last, want.run_last));
                    if (cp1252_bus.text_done !== want.text_done)
                        report_mismatch($sformatf("result %0d text_done %b, want %b",
                            cp1252_seen, cp1252_bus.text_done, want.text_done));
                end
            end
            if (long_hold)
            begin
                cp1252_bus.ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                cp1252_bus.ready <= 1'b0;
            end
            else if (utf8_taken < utf8_total - QUIET_TAIL &&
                     $urandom_range(99) < recv_idle_pct)
            begin
                recv_gap = $urandom_range(8);
                cp1252_bus.ready <= 1'b0;
            end
            else
            begin
                cp1252_bus.ready <= 1'b1;
            end
        end
    end

    // One long receiver hold-off so the result queue fills and input backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold <= 1'b0;
            hold_done <= 1'b0;
            hold_left <= 0;
        end
        else if (long_hold)
        begin
            if (hold_left == 0)
                long_hold <= 1'b0;
            else
                hold_left <= hold_left - 1;
        end
        else if (!hold_done && utf8_taken >= HOLD_AT)
        begin
            long_hold <= 1'b1;
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Watchdog: too many cycles without a request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((utf8_bus.valid && utf8_bus.ready) || (cp1252_bus.valid && cp1252_bus.ready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("[%0t] no progress for %0d cycles", $realtime, stuck_cycles);
                $display("utf8_to_cp1252_transcoder_core test failed");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int          pick;
        int          len;
        logic [20:0] cp;
        logic [7:0]  lead;
        rst_n                = 1'b0;
        utf8_bus.valid       = 1'b0;
        utf8_bus.in_byte     = 8'h00;
        utf8_bus.end_of_text = 1'b0;
        cp1252_bus.ready     = 1'b0;
        stuck_cycles         = 0;
        mismatches           = 0;
        utf8_total           = DIRECTED_MAX + RANDOM_ITEMS;
        for (int k = 0; k < 32; k++)
            high_byte_of[int'(HIGH_CP[k])] = u2c_pkg::HIGH_BASE + 8'(k);

        // Directed: ASCII extremes incl. zero, stray continuations
        queue_byte(8'h00);
        queue_byte(8'h7f);
        queue_byte(8'h80);
        queue_byte(8'hbf);
        // top of the pass-through range, euro sign, last table entry
        queue_code_point(21'h0000ff, 2, 1'b0);
        queue_code_point(21'h0020ac, 3, 1'b0);
        queue_code_point(21'h000178, 2, 1'b0);
        // four-byte character with no cp1252 byte
        queue_code_point(21'h01f600, 4, 1'b0);
        // sequence cut short by ASCII, then by another lead
        queue_byte(8'he2);
        queue_byte(8'h41);
        queue_byte(8'hc3);
        queue_code_point(21'h0000e9, 2, 1'b0);
        // lead above 0xF7 cut short
        queue_byte(8'hff);
        queue_byte(8'h41);
        // end of text with and without a partial sequence
        queue_byte(8'hc3);
        queue_eot(8'hff);
        queue_eot(8'h00);

        // Random: mostly well-formed text, some broken sequences and noise
        while (utf8_backlog.size() < utf8_total)
        begin
            pick = $urandom_range(99);
            if (pick < 82)
            begin
                if (pick < 20)
                    cp = 21'($urandom_range(8'h7f));
                else if (pick < 35)
                    cp = 21'($urandom_range(8'hff, 8'ha0));
                else if (pick < 55)
                    cp = HIGH_CP[$urandom_range(31)];
                else if (pick < 62)
                    cp = 21'($urandom_range(8'h9f, 8'h80));
                else if (pick < 75)
                    cp = 21'($urandom_range(16'hffff, 16'h0100));
                else
                    cp = 21'($urandom_range(21'h1fffff, 21'h010000));
                len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
                // occasional overlong form
                if (len < 4 && $urandom_range(19) == 0)
                    len++;
                queue_code_point(cp, len, len > 1 && $urandom_range(14) == 0);
            end
            else if (pick < 92)
            begin
                queue_byte(8'($urandom_range(255)));
            end
            else if (pick < 96)
            begin
                lead = 8'($urandom_range(8'hff, u2c_pkg::LEAD2_MIN));
                queue_byte(lead);
                queue_byte(8'($urandom_range(255)));
            end
            else
            begin
                queue_eot(8'($urandom_range(255)));
            end
        end
        utf8_total = utf8_backlog.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (utf8_backlog.size() == 0 && cp1252_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("utf8_to_cp1252_transcoder_core test passed");
        else
            $display("utf8_to_cp1252_transcoder_core test failed");
        $finish;
    end

endmodule
